/* hdl/dpb_pkg.sv */
// Shared types and constants for the depth back-projector.
package dpb_pkg;

  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 24;
  localparam int IDX_BITS   = $clog2(COORD_BITS);
  localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX  = 32'h8000_0000;
  // millimetres to Q16.16: (raw * 8192 + 62) / 125 by reciprocal multiply
  localparam logic [29:0] MM_BIAS  = 30'd62;
  localparam logic [30:0] MM_RECIP = 31'd1099511628;
  localparam int          MM_SHIFT = 37;

  typedef enum logic [2:0] {
    REG_DEPTH_SIZE,
    REG_COLOR_SIZE,
    REG_FOCAL,
    REG_CENTER,
    REG_STRIDE,
    REG_MAX_POINTS,
    REG_FORMAT
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] dw;
    logic [15:0] dh;
    logic [15:0] cw;
    logic [15:0] ch;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [7:0]  stride;
    logic [23:0] pt_limit;
    logic        fmt;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] u;
    logic [COORD_BITS-1:0] v;
    logic [31:0]           zq;
    logic                  mm;
  } job_t;

  typedef enum logic [0:0] {FR_RUN, FR_REM} fr_state_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_ZLOAD, BK_XLOAD, BK_XDIV, BK_YLOAD, BK_YDIV,
    BK_CLOAD, BK_CDIV, BK_RLOAD, BK_RDIV, BK_OUT
  } bk_state_t;

endpackage

/* hdl/dpb_intf.sv */
// Beat channels: depth samples in, points out.
interface dpb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] depth_sample;
  logic        frame_start;
  modport source (output valid, depth_sample, frame_start, input ready);
  modport sink (input valid, depth_sample, frame_start, output ready);
endinterface

interface dpb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [30:0]        point_z;
  logic [15:0]        color_col;
  logic [15:0]        color_row;
  modport source (output valid, point_x, point_y, point_z, color_col, color_row,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, color_col, color_row,
                output ready);
endinterface

/* hdl/dpb_div.sv */
// Restoring divider, one quotient bit per cycle.
module dpb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] acc_r;
  logic [31:0] rem_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic        ge;

  assign trial = {rem_r, acc_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[62:0], ge};
      rem_r <= ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];
    end
  end

  assign done = done_r;
  assign quo  = acc_r;
endmodule

/* hdl/dpb_queue.sv */
// Two-entry job queue between front and back.
module dpb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dpb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dpb_pkg::job_t pop_job
);
  import dpb_pkg::*;

  job_t       mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_job;
  end

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem[rp_r];
endmodule

/* hdl/dpb_front.sv */
// Front: pixel counters, stride selection, point limit and depth decode.
module dpb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  dpb_pkg::cfg_t cfg,
  input  logic          stride_wr,
  dpb_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output dpb_pkg::job_t job
);
  import dpb_pkg::*;

  fr_state_t state_r, state_nxt;
  logic [COORD_BITS-1:0] col_r, row_r, u, v;
  logic [COUNT_BITS-1:0] pe_r, pe;
  logic [7:0] cph_r, rph_r, cph, rph, st;
  logic [7:0] crem_r, rrem_r;
  logic [IDX_BITS-1:0] idx_r;
  logic stale_r, fire, keep, ok, cfg_ok, wrap;
  logic [8:0] ct, rt;
  logic [7:0] ex, ex_eff, r;
  logic [23:0] man;
  logic [31:0] fz, sv;

  assign st = (cfg.stride == 8'd0) ? 8'd1 : cfg.stride;

  assign u   = in_ch.frame_start ? '0 : col_r;
  assign v   = in_ch.frame_start ? '0 : row_r;
  assign pe  = in_ch.frame_start ? '0 : pe_r;
  assign cph = in_ch.frame_start ? '0 : cph_r;
  assign rph = in_ch.frame_start ? '0 : rph_r;

  assign ex     = in_ch.depth_sample[30:23];
  assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;
  assign man    = {ex != 8'd0, in_ch.depth_sample[22:0]};
  assign r      = 8'd134 - ex_eff;

  always_comb begin
    sv = 32'(man) << (ex_eff - 8'd134);
    if (ex_eff >= 8'd142) fz = Q_MAX;
    else if (ex_eff >= 8'd134) fz = (sv > Q_MAX) ? Q_MAX : sv;
    else if (ex_eff <= 8'd109) fz = '0;
    else fz = (32'(man) + (32'd1 << (r - 8'd1))) >> r;
  end

  assign ok = cfg.fmt ? !(in_ch.depth_sample[31] || ex == 8'hFF ||
                          (ex == 8'd0 && in_ch.depth_sample[22:0] == '0))
                      : in_ch.depth_sample[15:0] != 16'd0;

  assign cfg_ok = cfg.fx != '0 && cfg.fy != '0 && cfg.dw != '0 && cfg.dh != '0 &&
                  cfg.cw != '0 && cfg.ch != '0;

  assign keep = cfg_ok && 32'(u) < 32'(cfg.dw) && 32'(v) < 32'(cfg.dh) &&
                cph == 8'd0 && rph == 8'd0 &&
                !(cfg.pt_limit != '0 && 32'(pe) >= 32'(cfg.pt_limit)) && ok;

  assign in_ch.ready = state_r == FR_RUN && !stale_r && !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign push        = fire && keep;

  assign job.u  = u;
  assign job.v  = v;
  assign job.zq = cfg.fmt ? fz : {16'd0, in_ch.depth_sample[15:0]};
  assign job.mm = !cfg.fmt;

  assign wrap = (33'(u) + 33'd1 >= 33'(cfg.dw)) || (u == '1);

  // serial remainder steps, column and row in parallel
  assign ct = {crem_r, col_r[idx_r]};
  assign rt = {rrem_r, row_r[idx_r]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FR_RUN: if (stale_r) state_nxt = FR_REM;
      FR_REM: if (idx_r == '0) state_nxt = FR_RUN;
      default: state_nxt = FR_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FR_RUN;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      pe_r    <= '0;
      cph_r   <= '0;
      rph_r   <= '0;
      stale_r <= 1'b0;
      idx_r   <= '0;
      crem_r  <= '0;
      rrem_r  <= '0;
    end else begin
      stale_r <= stride_wr || (stale_r && state_r != FR_RUN);
      if (state_r == FR_RUN && stale_r) begin
        idx_r   <= IDX_BITS'(COORD_BITS - 1);
        crem_r  <= '0;
        rrem_r  <= '0;
      end else if (state_r == FR_REM) begin
        crem_r <= (ct >= {1'b0, st}) ? 8'(ct - {1'b0, st}) : ct[7:0];
        rrem_r <= (rt >= {1'b0, st}) ? 8'(rt - {1'b0, st}) : rt[7:0];
        idx_r  <= idx_r - IDX_BITS'(1);
        if (idx_r == '0) begin
          cph_r <= (ct >= {1'b0, st}) ? 8'(ct - {1'b0, st}) : ct[7:0];
          rph_r <= (rt >= {1'b0, st}) ? 8'(rt - {1'b0, st}) : rt[7:0];
        end
      end else if (fire) begin
        pe_r <= (push && pe != '1) ? pe + COUNT_BITS'(1) : pe;
        if (wrap) begin
          col_r <= '0;
          cph_r <= '0;
          if (v != '1) begin
            row_r <= v + COORD_BITS'(1);
            rph_r <= (rph + 8'd1 == st) ? 8'd0 : rph + 8'd1;
          end else begin
            row_r <= v;
            rph_r <= rph;
          end
        end else begin
          col_r <= u + COORD_BITS'(1);
          cph_r <= (cph + 8'd1 == st) ? 8'd0 : cph + 8'd1;
          row_r <= v;
          rph_r <= rph;
        end
      end
    end
  end
endmodule

/* hdl/dpb_back.sv */
// Back: depth scaling, projection and color mapping on a shared divider.
module dpb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dpb_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  dpb_pkg::job_t q_job,
  output logic          pop,
  dpb_out_if.source     out_ch
);
  import dpb_pkg::*;

  bk_state_t state_r, state_nxt;
  job_t        job_r;
  logic [31:0] zq_r, px_r, py_r;
  logic [15:0] col_r, row_r;
  logic        neg_r, neg;
  logic        start, done;
  logic [63:0] num, quo;
  logic [31:0] den, pos, ctr, d;
  logic [31:0] sat;
  logic [63:0] clamp;
  logic [29:0] mm_k;
  logic [60:0] mm_prod;

  assign mm_k    = 30'({job_r.zq[15:0], 13'd0}) + MM_BIAS;
  assign mm_prod = {31'd0, mm_k} * {30'd0, MM_RECIP};

  always_comb begin
    pos = 32'(job_r.u) << 16;
    ctr = cfg.cx;
    if (state_r == BK_YLOAD) begin
      pos = 32'(job_r.v) << 16;
      ctr = cfg.cy;
    end
    neg = pos < ctr;
    d   = neg ? ctr - pos : pos - ctr;
  end

  always_comb begin
    start = 1'b0;
    num   = '0;
    den   = '0;
    unique case (state_r)
      BK_XLOAD: begin
        start = 1'b1;
        num   = 64'(d) * 64'(zq_r);
        den   = cfg.fx;
      end
      BK_YLOAD: begin
        start = 1'b1;
        num   = 64'(d) * 64'(zq_r);
        den   = cfg.fy;
      end
      BK_CLOAD: begin
        start = 1'b1;
        num   = 64'(job_r.u) * 64'(cfg.cw);
        den   = 32'(cfg.dw);
      end
      BK_RLOAD: begin
        start = 1'b1;
        num   = 64'(job_r.v) * 64'(cfg.ch);
        den   = 32'(cfg.dh);
      end
      default: ;
    endcase
  end

  dpb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .num  (num),
    .den  (den),
    .done (done),
    .quo  (quo)
  );

  always_comb begin
    if (neg_r) sat = 32'd0 - ((quo > 64'(NEG_MAX)) ? NEG_MAX : quo[31:0]);
    else sat = (quo > 64'(Q_MAX)) ? Q_MAX : quo[31:0];
  end

  always_comb begin
    clamp = (state_r == BK_RDIV) ? 64'(cfg.ch) - 64'd1 : 64'(cfg.cw) - 64'd1;
    if (quo < clamp) clamp = quo;
  end

  assign pop = state_r == BK_IDLE && !q_empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = q_job.mm ? BK_ZLOAD : BK_XLOAD;
      BK_ZLOAD: state_nxt = BK_XLOAD;
      BK_XLOAD: state_nxt = BK_XDIV;
      BK_XDIV:  if (done) state_nxt = BK_YLOAD;
      BK_YLOAD: state_nxt = BK_YDIV;
      BK_YDIV:  if (done) state_nxt = BK_CLOAD;
      BK_CLOAD: state_nxt = BK_CDIV;
      BK_CDIV:  if (done) state_nxt = BK_RLOAD;
      BK_RLOAD: state_nxt = BK_RDIV;
      BK_RDIV:  if (done) state_nxt = BK_OUT;
      BK_OUT:   if (out_ch.ready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
      zq_r  <= q_job.zq;
    end
    if (state_r == BK_ZLOAD) zq_r <= 32'(mm_prod >> MM_SHIFT);
    if (state_r == BK_XLOAD || state_r == BK_YLOAD) neg_r <= neg;
    if (done) begin
      unique case (state_r)
        BK_XDIV: px_r  <= sat;
        BK_YDIV: py_r  <= sat;
        BK_CDIV: col_r <= clamp[15:0];
        BK_RDIV: row_r <= clamp[15:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = state_r == BK_OUT;
  assign out_ch.point_x   = px_r;
  assign out_ch.point_y   = py_r;
  assign out_ch.point_z   = zq_r[30:0];
  assign out_ch.color_col = col_r;
  assign out_ch.color_row = row_r;
endmodule

/* hdl/depth_to_point_back_projector.sv */
// Depth pixel to 3-D point back-projector, top level.
// Front takes one pixel a cycle unless the queue is full or a stride write is
// recomputing the stride phase; stride-dropped or invalid pixels are never queued.
// Each kept pixel runs 4 divisions on the shared divider in the back end, plus
// a depth scaling step for millimetre input, plus any output stall.
// Synchronous active-low reset clears counters and queue; config gets defaults.
module depth_to_point_back_projector (
  input  logic        clk,
  input  logic        rst_n,
  dpb_in_if.sink      in_ch,
  dpb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dpb_pkg::*;

  cfg_t cfg_r;
  job_t f_job, q_job;
  logic push, pop, q_full, q_empty, stride_wr;

  assign stride_wr = cfg_we && cfg_reg_t'(cfg_index) == REG_STRIDE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dw         <= 16'd1280;
      cfg_r.dh         <= 16'd480;
      cfg_r.cw         <= 16'd1280;
      cfg_r.ch         <= 16'd480;
      cfg_r.fx         <= '0;
      cfg_r.fy         <= '0;
      cfg_r.cx         <= '0;
      cfg_r.cy         <= '0;
      cfg_r.stride     <= 8'd2;
      cfg_r.pt_limit   <= 24'd100000;
      cfg_r.fmt        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEPTH_SIZE: {cfg_r.dh, cfg_r.dw} <= cfg_data[31:0];
        REG_COLOR_SIZE: {cfg_r.ch, cfg_r.cw} <= cfg_data[31:0];
        REG_FOCAL:      {cfg_r.fy, cfg_r.fx} <= cfg_data;
        REG_CENTER:     {cfg_r.cy, cfg_r.cx} <= cfg_data;
        REG_STRIDE:     cfg_r.stride <= cfg_data[7:0];
        REG_MAX_POINTS: cfg_r.pt_limit <= cfg_data[23:0];
        REG_FORMAT:     cfg_r.fmt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dpb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .stride_wr(stride_wr),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .job      (f_job)
  );

  dpb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(f_job),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .pop_job (q_job)
  );

  dpb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_empty(q_empty),
    .q_job  (q_job),
    .pop    (pop),
    .out_ch (out_ch)
  );
endmodule

/* verif/dpb_checker.sv */
// Point checker: watches the depth, point and config ports and predicts every point.
module dpb_checker
  import dpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dpb_in_if           in_mon,
  dpb_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          points_due,
  output int          points_seen
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        z;
    logic [15:0]        col;
    logic [15:0]        row;
  } point_t;

  point_t      point_q[$];
  cfg_t        cam;
  logic [15:0] col_cnt, row_cnt;
  logic [23:0] emitted;

  assign points_due = point_q.size();

  function automatic bit decode_z(input logic [31:0] s, input logic flt,
                                  output logic [63:0] zq);
    logic [7:0]  ex;
    logic [63:0] man;
    int          sh;
    zq = '0;
    if (!flt) begin
      if (s[15:0] == 16'd0) return 1'b0;
      zq = ({48'd0, s[15:0]} * 64'd65536 + 64'd500) / 64'd1000;
      return 1'b1;
    end
    ex  = s[30:23];
    man = {41'd0, s[22:0]};
    if (s[31] || ex == 8'hFF || (ex == 8'd0 && man == 0)) return 1'b0;
    if (ex != 8'd0) man[23] = 1'b1;
    else ex = 8'd1;
    sh = int'(ex) - 134;
    if (sh >= 8) zq = 64'h7FFF_FFFF;
    else if (sh >= 0) begin
      zq = man << sh;
      if (zq > 64'h7FFF_FFFF) zq = 64'h7FFF_FFFF;
    end else if (sh <= -25) zq = 0;
    else zq = (man + (64'd1 << (-sh - 1))) >> (-sh);
    return 1'b1;
  endfunction

  function automatic logic [31:0] back_project(input logic [15:0] coord,
      input logic [31:0] center, input logic [63:0] zq, input logic [31:0] focal);
    logic [63:0]  pos, d;
    logic [127:0] mag;
    bit           neg;
    pos = {32'd0, coord, 16'd0};
    neg = pos < {32'd0, center};
    d   = neg ? {32'd0, center} - pos : pos - {32'd0, center};
    mag = ({64'd0, d} * {64'd0, zq}) / {96'd0, focal};
    if (neg) begin
      if (mag > 128'h8000_0000) mag = 128'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic logic [15:0] color_pos(input logic [15:0] p,
      input logic [15:0] csz, input logic [15:0] dsz);
    logic [31:0] c;
    c = ({16'd0, p} * {16'd0, csz}) / {16'd0, dsz};
    return (c > csz - 1) ? csz - 16'd1 : c[15:0];
  endfunction

  task automatic predict_pixel(input logic [31:0] s, input logic fs);
    logic [7:0]  stride;
    logic [15:0] u, v;
    logic [63:0] zq;
    point_t      p;
    stride = (cam.stride == 0) ? 8'd1 : cam.stride;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
      emitted = 0;
    end
    u = col_cnt;
    v = row_cnt;
    if (cam.fx != 0 && cam.fy != 0 && cam.dw != 0 && cam.dh != 0 && cam.cw != 0
        && cam.ch != 0 && u < cam.dw && v < cam.dh && u % stride == 0
        && v % stride == 0 && !(cam.pt_limit != 0 && emitted >= cam.pt_limit)
        && decode_z(s, cam.fmt, zq)) begin
      p.x   = back_project(u, cam.cx, zq, cam.fx);
      p.y   = back_project(v, cam.cy, zq, cam.fy);
      p.z   = zq[30:0];
      p.col = color_pos(u, cam.cw, cam.dw);
      p.row = color_pos(v, cam.ch, cam.dh);
      point_q.insert(point_q.size(), p);
      if (emitted != 24'hFF_FFFF) emitted++;
    end
    if ({16'd0, u} + 32'd1 >= {16'd0, cam.dw} || u == 16'hFFFF) begin
      col_cnt = 0;
      if (row_cnt != 16'hFFFF) row_cnt++;
    end else col_cnt = u + 16'd1;
  endtask

  always @(posedge clk) begin
    point_t e;
    if (!rst_n) begin
      cam = '{dw: 16'd1280, dh: 16'd480, cw: 16'd1280, ch: 16'd480, fx: 0, fy: 0,
             cx: 0, cy: 0, stride: 8'd2, pt_limit: 24'd100000, fmt: 1'b0};
      col_cnt = 0;
      row_cnt = 0;
      emitted = 0;
      point_q.delete();
      fail_count  = 0;
      points_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        points_seen++;
        if (point_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected point beat x=%h", out_mon.point_x);
        end else begin
          e = point_q.pop_front();
          if (e.x !== out_mon.point_x || e.y !== out_mon.point_y ||
              e.z !== out_mon.point_z || e.col !== out_mon.color_col ||
              e.row !== out_mon.color_row) begin
            fail_count++;
            if (fail_count <= 10)
              $display("point mismatch: exp %h %h %h %h %h got %h %h %h %h %h",
                       e.x, e.y, e.z, e.col, e.row, out_mon.point_x, out_mon.point_y,
                       out_mon.point_z, out_mon.color_col, out_mon.color_row);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_pixel(in_mon.depth_sample, in_mon.frame_start);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEPTH_SIZE: {cam.dh, cam.dw} = cfg_data[31:0];
          REG_COLOR_SIZE: {cam.ch, cam.cw} = cfg_data[31:0];
          REG_FOCAL:      {cam.fy, cam.fx} = cfg_data;
          REG_CENTER:     {cam.cy, cam.cx} = cfg_data;
          REG_STRIDE:     cam.stride = cfg_data[7:0];
          REG_MAX_POINTS: cam.pt_limit = cfg_data[23:0];
          REG_FORMAT:     cam.fmt = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* verif/testbench.sv */
// Testbench top: clock, reset, pixel and config stimulus, and the verdict.
module testbench;
  import dpb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count, points_due, points_seen;
  int          send_idle, recv_stall, pixels_sent, settings_run;
  logic        hold_req, hold_done;
  int          hold_cnt;

  dpb_in_if  in_ch ();
  dpb_out_if out_ch ();

  depth_to_point_back_projector DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dpb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .points_due(points_due), .points_seen(points_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_cnt = hold_cnt + 1;
        if (hold_cnt >= 3000) hold_done <= 1'b1;
      end else
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic cfg_write(input cfg_reg_t r, input logic [63:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (points_due != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [31:0] s, input logic fs);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.depth_sample <= s;
    in_ch.frame_start  <= fs;
    do @(posedge clk); while (!in_ch.ready);
    pixels_sent++;
  endtask

  function automatic logic [31:0] rand_depth(input logic flt);
    if (flt && $urandom_range(3) != 0)
      return {1'b0, 8'($urandom_range(140, 110)), 23'($urandom)};
    if (!flt && $urandom_range(7) == 0) return {16'($urandom), 16'd0};
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_size(input int hi);
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'($urandom);
      default: return 16'($urandom_range(hi, 1));
    endcase
  endfunction

  task automatic setup_random();
    logic [15:0] dw, dh;
    logic        flt;
    dw  = rand_size(7);
    dh  = rand_size(6);
    flt = 1'($urandom_range(1));
    cfg_write(REG_DEPTH_SIZE, $urandom_range(19) == 0 ? 64'd0 : {32'd0, dh, dw});
    cfg_write(REG_COLOR_SIZE, {32'd0, rand_size(20), rand_size(20)});
    case ($urandom_range(5))
      0: cfg_write(REG_FOCAL, 64'hFFFF_FFFF_FFFF_FFFF);
      1: cfg_write(REG_FOCAL, {32'($urandom_range(3, 1)), 32'($urandom_range(3, 1))});
      2: cfg_write(REG_FOCAL, {$urandom, $urandom});
      default: cfg_write(REG_FOCAL, {32'($urandom_range(32'h0400_0000, 32'h1_0000)),
                                     32'($urandom_range(32'h0400_0000, 32'h1_0000))});
    endcase
    case ($urandom_range(3))
      0: cfg_write(REG_CENTER, 64'hFFFF_FFFF_FFFF_FFFF);
      1: cfg_write(REG_CENTER, {$urandom, $urandom});
      default: cfg_write(REG_CENTER, {32'($urandom_range(32'h8_0000)),
                                      32'($urandom_range(32'h8_0000))});
    endcase
    case ($urandom_range(5))
      0: cfg_write(REG_STRIDE, 64'd255);
      1: cfg_write(REG_STRIDE, 64'($urandom_range(255, 1)));
      2: cfg_write(REG_STRIDE, 64'd2);
      default: cfg_write(REG_STRIDE, 64'd1);
    endcase
    case ($urandom_range(3))
      0: cfg_write(REG_MAX_POINTS, 64'hFF_FFFF);
      1: cfg_write(REG_MAX_POINTS, 64'($urandom_range(5, 1)));
      default: cfg_write(REG_MAX_POINTS, 64'd0);
    endcase
    cfg_write(REG_FORMAT, {63'd0, flt});
  endtask

  initial begin
    logic [31:0] floats[8];
    int          n, pix, flen;
    logic        flt;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.depth_sample = '0;
    in_ch.frame_start = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    pixels_sent = 0;
    settings_run = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // millimetres, 4x2 image, negative-side center on y
    cfg_write(REG_DEPTH_SIZE, {32'd0, 16'd2, 16'd4});
    cfg_write(REG_COLOR_SIZE, {32'd0, 16'd3, 16'd8});
    cfg_write(REG_FOCAL, {32'h0002_0000, 32'h0001_0000});
    cfg_write(REG_CENTER, {32'hFFFF_FFFF, 32'h0001_8000});
    cfg_write(REG_STRIDE, 64'd1);
    cfg_write(REG_MAX_POINTS, 64'd0);
    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h0000_FFFF, 1'b0);
    send_pixel(32'hFFFF_03E8, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0200, 1'b0);
    send_pixel(32'h8000_0001, 1'b0);
    send_pixel(32'h0001_0000, 1'b0);
    drain();
    // floats: one, negative, inf, nan, denormal, max, zero, tiny
    cfg_write(REG_FORMAT, 64'd1);
    floats = '{32'h3F80_0000, 32'h8000_0001, 32'h7F80_0000, 32'h7FC0_0001,
               32'h0000_0001, 32'h7F7F_FFFF, 32'h0000_0000, 32'h3300_0000};
    foreach (floats[i]) send_pixel(floats[i], i == 0);
    drain();
    // point limit, then zero focal length
    cfg_write(REG_MAX_POINTS, 64'd2);
    repeat (4) send_pixel(32'h3F80_0000, 1'b0);
    send_pixel(32'h4000_0000, 1'b1);
    drain();
    cfg_write(REG_FOCAL, {32'h0001_0000, 32'd0});
    send_pixel(32'h3F80_0000, 1'b1);
    send_pixel(32'h3F80_0000, 1'b0);
    drain();

    n = 0;
    while (n < 600) begin
      setup_random();
      settings_run++;
      case (settings_run % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      if (settings_run == 3) hold_req = 1'b1;
      flt = chk.cam.fmt;
      flen = (chk.cam.dw * chk.cam.dh > 48 || chk.cam.dw == 0) ? 20
             : chk.cam.dw * chk.cam.dh;
      for (int f = 0; f < 3 && n < 600; f++) begin
        for (pix = 0; pix < flen; pix++) begin
          if ($urandom_range(9) == 0)
            send_pixel(rand_depth(flt), 1'($urandom_range(1)));
          else send_pixel(rand_depth(flt), pix == 0);
          n++;
        end
      end
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();

    $display("covered %0d pixels over %0d random camera setups, %0d points checked",
             pixels_sent, settings_run, points_seen);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
